FILE: rtl/core/crt_pkg.sv
// Shared types and codes for the capture run table.
package crt_pkg;

    localparam logic [2:0] MODE_OPEN   = 3'd0;
    localparam logic [2:0] MODE_APPEND = 3'd1;
    localparam logic [2:0] MODE_READ   = 3'd2;
    localparam logic [2:0] MODE_FLUSH  = 3'd3;
    localparam logic [2:0] MODE_CLOSE  = 3'd4;

    localparam logic [4:0] ST_OK          = 5'd0;
    localparam logic [4:0] ST_ALREADY     = 5'd1;
    localparam logic [4:0] ST_STRIDE      = 5'd2;
    localparam logic [4:0] ST_CHANNELS    = 5'd3;
    localparam logic [4:0] ST_RATE_ZERO   = 5'd4;
    localparam logic [4:0] ST_MASK        = 5'd5;
    localparam logic [4:0] ST_NOT_OPEN    = 5'd6;
    localparam logic [4:0] ST_HEADER      = 5'd7;
    localparam logic [4:0] ST_GEOMETRY    = 5'd8;
    localparam logic [4:0] ST_LENGTH      = 5'd9;
    localparam logic [4:0] ST_OVERLAP     = 5'd10;
    localparam logic [4:0] ST_TABLE_FULL  = 5'd11;
    localparam logic [4:0] ST_NO_DATA     = 5'd12;
    localparam logic [4:0] ST_BUF_SMALL   = 5'd13;
    localparam logic [4:0] ST_SPANS_HOLE  = 5'd14;
    localparam logic [4:0] ST_OUTSIDE     = 5'd15;
    localparam logic [4:0] ST_CORRUPT     = 5'd16;

    localparam logic [1:0] REG_STRIDE   = 2'd0;
    localparam logic [1:0] REG_CHANNELS = 2'd1;
    localparam logic [1:0] REG_RATE     = 2'd2;
    localparam logic [1:0] REG_MASK     = 2'd3;

    localparam int MAX_CHANNELS = 32;

    typedef struct packed {
        logic [2:0]  mode;
        logic [47:0] first_index;
        logic [31:0] sample_count;
        logic        header_ok;
        logic [2:0]  block_stride;
        logic [5:0]  block_channels;
        logic [31:0] block_rate;
        logic [33:0] payload_len;
        logic [33:0] buffer_bytes;
    } t_crt_in;

    typedef struct packed {
        logic [4:0]  status;
        logic [39:0] byte_offset;
        logic [31:0] samples_read;
        logic        hole_recorded;
        logic [47:0] hole_size;
        logic [31:0] blocks_written;
        logic [31:0] blocks_rejected;
        logic [47:0] samples_written;
        logic [39:0] bytes_written;
        logic [39:0] bytes_durable;
        logic [31:0] holes_recorded;
        logic [47:0] missing_total;
    } t_crt_out;

    typedef struct packed {
        logic [47:0] first;
        logic [47:0] last;
        logic [39:0] base;
    } t_run;

    typedef struct packed {
        logic load;
        logic exec_commit;
        logic scan_start;
        logic scan_step;
        logic off_calc;
        logic read_commit;
    } t_crt_cmd;

    typedef struct packed {
        logic out_free;
        logic need_scan;
        logic scan_hit;
        logic scan_miss;
    } t_crt_sts;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_OFF,
        S_DONE
    } t_state;

endpackage

FILE: rtl/core/crt_ctrl.sv
// Sequencer for item execution and the run table scan.
module crt_ctrl import crt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_crt_sts i_sts,
    output t_crt_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.need_scan) n_state = S_SCAN;
                else if (i_sts.out_free) n_state = S_IDLE;
            end
            S_SCAN: begin
                if (i_sts.scan_hit) n_state = S_OFF;
                else if (i_sts.scan_miss) n_state = S_DONE;
            end
            S_OFF: n_state = S_DONE;
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.scan_start = i_sts.need_scan;
                o_cmd.exec_commit = !i_sts.need_scan && i_sts.out_free;
            end
            S_SCAN: o_cmd.scan_step = !i_sts.scan_hit && !i_sts.scan_miss;
            S_OFF: o_cmd.off_calc = 1'b1;
            S_DONE: o_cmd.read_commit = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: rtl/core/crt_dp.sv
// Datapath: registers, run table memory, checks, counters and result register.
module crt_dp import crt_pkg::*; #(
    parameter int MAX_RUNS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    input  t_crt_in     i_in_data,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output t_crt_out    o_out_data,
    input  t_crt_cmd    i_cmd,
    output t_crt_sts    o_sts
);

    localparam int IW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int CW = $clog2(MAX_RUNS + 1);

    // configuration and latched geometry
    logic [2:0]  r_cfg_stride;
    logic [5:0]  r_cfg_channels;
    logic [31:0] r_cfg_rate;
    logic [31:0] r_cfg_mask;
    logic [2:0]  r_geo_stride, n_geo_stride;
    logic [5:0]  r_geo_channels, n_geo_channels;
    logic [31:0] r_geo_rate, n_geo_rate;

    logic        r_open, n_open;
    logic [CW-1:0] r_runs, n_runs;
    t_run        r_last, n_last;
    logic [47:0] r_ext_start, n_ext_start;
    logic [47:0] r_ext_end, n_ext_end;
    logic [39:0] r_store, n_store;
    logic [31:0] r_blocks, n_blocks;
    logic [31:0] r_refused, n_refused;
    logic [47:0] r_samples, n_samples;
    logic [39:0] r_bytes, n_bytes;
    logic [39:0] r_durable, n_durable;
    logic [31:0] r_holes, n_holes;
    logic [47:0] r_missing, n_missing;

    t_crt_in     r_in;
    t_run        r_mem [MAX_RUNS];
    t_run        r_rd;
    t_run        r_hit;
    logic        r_rd_vld;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_rd_idx;
    logic        r_found;
    logic [51:0] r_off;

    logic        r_out_valid;
    t_crt_out    r_out;

    logic        cfg_we;
    logic        mem_we;
    logic [IW-1:0] mem_wa;
    t_run        mem_wd;
    logic [4:0]  ex_status;
    logic        ex_hole;
    logic [47:0] ex_hsize;
    logic [1:0]  shamt;
    logic [33:0] needed;
    logic [48:0] end49;
    logic [5:0]  pop;
    logic        issue;
    logic        hit;
    logic [48:0] rd_end;
    logic [4:0]  rd_status;
    logic [52:0] off_need;
    logic [47:0] diff;
    logic        out_free;
    logic [40:0] sum40;
    logic [48:0] miss48;
    logic [48:0] samp48;
    logic [40:0] bytes40;

    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_stride   <= 3'd1;
            r_cfg_channels <= 6'd1;
            r_cfg_rate     <= 32'd1000000;
            r_cfg_mask     <= 32'd1;
        end else if (cfg_we) begin
            case (paddr[3:2])
                REG_STRIDE:   r_cfg_stride   <= pwdata[2:0];
                REG_CHANNELS: r_cfg_channels <= pwdata[5:0];
                REG_RATE:     r_cfg_rate     <= pwdata;
                REG_MASK:     r_cfg_mask     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_STRIDE:   prdata = {29'd0, r_cfg_stride};
            REG_CHANNELS: prdata = {26'd0, r_cfg_channels};
            REG_RATE:     prdata = r_cfg_rate;
            REG_MASK:     prdata = r_cfg_mask;
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        pop = '0;
        for (int k = 0; k < MAX_CHANNELS; k++) begin
            pop = pop + {5'd0, r_cfg_mask[k]};
        end
    end

    // geometry stride is always 1, 2 or 4, so the multiply is a shift
    assign shamt  = r_geo_stride[2:1];
    assign needed = {2'd0, r_in.sample_count} << shamt;
    assign end49  = {1'b0, r_in.first_index} + {17'd0, r_in.sample_count};
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_geo_stride   = r_geo_stride;
        n_geo_channels = r_geo_channels;
        n_geo_rate     = r_geo_rate;
        n_open    = r_open;
        n_runs    = r_runs;
        n_last    = r_last;
        n_ext_start = r_ext_start;
        n_ext_end = r_ext_end;
        n_store   = r_store;
        n_blocks  = r_blocks;
        n_refused = r_refused;
        n_samples = r_samples;
        n_bytes   = r_bytes;
        n_durable = r_durable;
        n_holes   = r_holes;
        n_missing = r_missing;
        ex_status = ST_OK;
        ex_hole   = 1'b0;
        ex_hsize  = '0;
        mem_we    = 1'b0;
        mem_wa    = '0;
        mem_wd    = r_last;
        sum40  = '0;
        miss48 = '0;
        samp48 = '0;
        bytes40 = '0;
        case (r_in.mode)
            MODE_OPEN: begin
                if (r_open) begin
                    ex_status = ST_ALREADY;
                end else if (r_cfg_stride != 3'd1 && r_cfg_stride != 3'd2 &&
                             r_cfg_stride != 3'd4) begin
                    ex_status = ST_STRIDE;
                end else if (r_cfg_channels == 6'd0 ||
                             r_cfg_channels > 6'(MAX_CHANNELS)) begin
                    ex_status = ST_CHANNELS;
                end else if (r_cfg_rate == 32'd0) begin
                    ex_status = ST_RATE_ZERO;
                end else if (pop != r_cfg_channels) begin
                    ex_status = ST_MASK;
                end else begin
                    n_geo_stride   = r_cfg_stride;
                    n_geo_channels = r_cfg_channels;
                    n_geo_rate     = r_cfg_rate;
                    n_runs = '0;
                    n_ext_start = '0;
                    n_ext_end = '0;
                    n_store = '0;
                    n_blocks = '0;
                    n_refused = '0;
                    n_samples = '0;
                    n_bytes = '0;
                    n_durable = '0;
                    n_holes = '0;
                    n_missing = '0;
                    n_open = 1'b1;
                end
            end
            MODE_APPEND: begin
                if (!r_open) begin
                    ex_status = ST_NOT_OPEN;
                end else begin
                    if (!r_in.header_ok) begin
                        ex_status = ST_HEADER;
                    end else if (r_in.block_stride != r_geo_stride ||
                                 r_in.block_channels != r_geo_channels ||
                                 r_in.block_rate != r_geo_rate) begin
                        ex_status = ST_GEOMETRY;
                    end else if (r_in.payload_len != needed || end49[48]) begin
                        ex_status = ST_LENGTH;
                    end else if (r_runs != '0 && r_in.first_index < r_last.last) begin
                        ex_status = ST_OVERLAP;
                    end else if (r_runs != '0 && r_in.first_index > r_last.last &&
                                 r_runs == CW'(MAX_RUNS)) begin
                        ex_status = ST_TABLE_FULL;
                    end
                    if (ex_status != ST_OK) begin
                        n_refused = (&r_refused) ? r_refused : r_refused + 32'd1;
                    end else begin
                        mem_we = 1'b1;
                        if (r_runs != '0 && r_in.first_index == r_last.last) begin
                            // extend the last run
                            mem_wa = IW'(r_runs - CW'(1));
                            n_last.last = end49[47:0];
                        end else begin
                            if (r_runs != '0) begin
                                ex_hole = 1'b1;
                                ex_hsize = r_in.first_index - r_last.last;
                                n_holes = (&r_holes) ? r_holes : r_holes + 32'd1;
                                miss48 = {1'b0, r_missing} + {1'b0, ex_hsize};
                                n_missing = miss48[48] ? '1 : miss48[47:0];
                            end
                            mem_wa = IW'(r_runs);
                            n_runs = r_runs + CW'(1);
                            n_last.first = r_in.first_index;
                            n_last.last  = end49[47:0];
                            n_last.base  = r_store;
                        end
                        mem_wd = n_last;
                        sum40 = {1'b0, r_store} + {7'd0, r_in.payload_len};
                        n_store = sum40[40] ? '1 : sum40[39:0];
                        if (r_ext_start == '0 && r_ext_end == '0) begin
                            n_ext_start = r_in.first_index;
                        end
                        n_ext_end = end49[47:0];
                        n_blocks = (&r_blocks) ? r_blocks : r_blocks + 32'd1;
                        samp48 = {1'b0, r_samples} + {17'd0, r_in.sample_count};
                        n_samples = samp48[48] ? '1 : samp48[47:0];
                        bytes40 = {1'b0, r_bytes} + {7'd0, r_in.payload_len};
                        n_bytes = bytes40[40] ? '1 : bytes40[39:0];
                    end
                end
            end
            MODE_READ: begin
                if (r_runs == '0) begin
                    ex_status = ST_NO_DATA;
                end else if (r_in.sample_count != '0 && r_in.buffer_bytes < needed) begin
                    ex_status = ST_BUF_SMALL;
                end
            end
            MODE_FLUSH: begin
                if (!r_open) ex_status = ST_NOT_OPEN;
                else n_durable = r_bytes;
            end
            MODE_CLOSE: begin
                if (r_open) begin
                    n_durable = r_bytes;
                    n_open = 1'b0;
                end
            end
            default: ex_status = ST_OK;
        endcase
    end

    // scan of the run table, one entry read per cycle
    assign issue  = i_cmd.scan_step && (r_idx < r_runs);
    assign rd_end = {1'b0, r_in.first_index} + {17'd0, r_in.sample_count};
    assign hit = r_rd_vld && (r_in.first_index >= r_rd.first) &&
                 (rd_end <= {1'b0, r_rd.last});
    assign diff = r_in.first_index - r_hit.first;
    assign off_need = {1'b0, r_off} + {19'd0, needed};

    always_comb begin
        if (r_found) begin
            rd_status = (off_need > {13'd0, r_store}) ? ST_CORRUPT : ST_OK;
        end else if (r_in.first_index >= r_ext_start && rd_end <= {1'b0, r_ext_end}) begin
            rd_status = ST_SPANS_HOLE;
        end else begin
            rd_status = ST_OUTSIDE;
        end
    end

    assign o_sts.out_free  = out_free;
    assign o_sts.need_scan = (r_in.mode == MODE_READ) && (r_runs != '0) &&
                             (r_in.sample_count != '0) && (r_in.buffer_bytes >= needed);
    assign o_sts.scan_hit  = hit;
    assign o_sts.scan_miss = r_rd_vld && !hit && (r_rd_idx == r_runs - CW'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec_commit && mem_we) r_mem[mem_wa] <= mem_wd;
        if (issue) r_rd <= r_mem[r_idx[IW-1:0]];
        if (i_cmd.load) r_in <= i_in_data;
        if (hit) r_hit <= r_rd;
        if (i_cmd.off_calc) r_off <= {12'd0, r_hit.base} + ({4'd0, diff} << shamt);
        if (i_cmd.exec_commit) r_last <= n_last;
        if (i_cmd.scan_step) begin
            r_rd_idx <= r_idx;
            if (issue) r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.scan_start) r_idx <= '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geo_stride   <= 3'd1;
            r_geo_channels <= 6'd1;
            r_geo_rate     <= 32'd1000000;
            r_open    <= 1'b0;
            r_runs    <= '0;
            r_ext_start <= '0;
            r_ext_end <= '0;
            r_store   <= '0;
            r_blocks  <= '0;
            r_refused <= '0;
            r_samples <= '0;
            r_bytes   <= '0;
            r_durable <= '0;
            r_holes   <= '0;
            r_missing <= '0;
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec_commit) begin
                r_geo_stride   <= n_geo_stride;
                r_geo_channels <= n_geo_channels;
                r_geo_rate     <= n_geo_rate;
                r_open    <= n_open;
                r_runs    <= n_runs;
                r_ext_start <= n_ext_start;
                r_ext_end <= n_ext_end;
                r_store   <= n_store;
                r_blocks  <= n_blocks;
                r_refused <= n_refused;
                r_samples <= n_samples;
                r_bytes   <= n_bytes;
                r_durable <= n_durable;
                r_holes   <= n_holes;
                r_missing <= n_missing;
            end
            // the read entry left over from the previous scan must not count here
            if (i_cmd.scan_start) begin
                r_rd_vld <= 1'b0;
                r_found  <= 1'b0;
            end else begin
                if (i_cmd.scan_step) r_rd_vld <= issue;
                if (hit) r_found <= 1'b1;
            end
            if (i_cmd.exec_commit || i_cmd.read_commit) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec_commit) begin
            r_out.status          <= ex_status;
            r_out.byte_offset     <= '0;
            r_out.samples_read    <= '0;
            r_out.hole_recorded   <= ex_hole;
            r_out.hole_size       <= ex_hsize;
            r_out.blocks_written  <= n_blocks;
            r_out.blocks_rejected <= n_refused;
            r_out.samples_written <= n_samples;
            r_out.bytes_written   <= n_bytes;
            r_out.bytes_durable   <= n_durable;
            r_out.holes_recorded  <= n_holes;
            r_out.missing_total   <= n_missing;
        end else if (i_cmd.read_commit) begin
            r_out.status          <= rd_status;
            r_out.byte_offset     <= (rd_status == ST_OK) ? r_off[39:0] : '0;
            r_out.samples_read    <= (rd_status == ST_OK) ? r_in.sample_count : '0;
            r_out.hole_recorded   <= 1'b0;
            r_out.hole_size       <= '0;
            r_out.blocks_written  <= r_blocks;
            r_out.blocks_rejected <= r_refused;
            r_out.samples_written <= r_samples;
            r_out.bytes_written   <= r_bytes;
            r_out.bytes_durable   <= r_durable;
            r_out.holes_recorded  <= r_holes;
            r_out.missing_total   <= r_missing;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/core/capture_run_table_with_holes.sv
// Capture run table: top level joining the sequencer and the datapath.
// Open, append, flush, close and short reads: the item is registered, then its
// result goes to the result register once that is free. Scanned reads read the run
// table one entry per cycle until a hit or a miss; on a hit the offset is computed.
// A new item is taken the cycle after the previous one has reached the result register.
// Synchronous active-low reset clears state, counters and geometry; the run
// table memory is not cleared (entries beyond the run count are never read).
module capture_run_table_with_holes import crt_pkg::*; #(
    parameter int MAX_RUNS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_crt_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_crt_out    o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_crt_cmd cmd;
    t_crt_sts sts;

    assign pready = 1'b1;

    crt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    crt_dp #(.MAX_RUNS(MAX_RUNS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the capture run table: random stimulus, scoreboard and APB setup.
module tb;
    import crt_pkg::*;

    localparam int RUNS = 64;
    localparam logic [63:0] M32 = 64'hFFFF_FFFF;
    localparam logic [63:0] M40 = 64'hFF_FFFF_FFFF;
    localparam logic [63:0] M48 = 64'hFFFF_FFFF_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_crt_in     i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_crt_out    o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    capture_run_table_with_holes #(.MAX_RUNS(RUNS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial forever #4 i_clk = ~i_clk;

    // register copy (what the block holds) and geometry latched at open
    logic [2:0]  reg_stride = 3'd1;
    logic [5:0]  reg_chan = 6'd1;
    logic [31:0] reg_rate = 32'd1000000;
    logic [31:0] reg_mask = 32'd1;
    logic [63:0] geo_stride = 64'd1, geo_chan = 64'd1, geo_rate = 64'd1000000;

    // run table state
    bit          cap_open = 1'b0;
    logic [63:0] run_first [RUNS];
    logic [63:0] run_stop [RUNS];
    logic [63:0] run_base [RUNS];
    int          runs_used = 0;
    logic [63:0] ext_lo = '0, ext_hi = '0, store_sz = '0;
    logic [63:0] n_blk = '0, n_rej = '0, n_smp = '0, n_byt = '0, n_dur = '0;
    logic [63:0] n_hole = '0, n_miss = '0;

    t_crt_in  pending_items[$];
    t_crt_out expected_results[$];
    int       fails = 0;
    int       gap_in = 0, gap_out = 0;
    bit       quiet = 1'b0;
    logic [63:0] cur = '0, span_lo = '0;

    task automatic enqueue(input t_crt_in x);
        pending_items.insert(pending_items.size(), x);
    endtask

    function automatic logic [63:0] sat(input logic [63:0] a, input logic [63:0] b,
                                        input logic [63:0] mx);
        if (a >= mx || b > mx - a) return mx;
        return a + b;
    endfunction

    // applies one item to the table copy and returns the result it must produce
    function automatic t_crt_out index_step(input t_crt_in x);
        t_crt_out r;
        logic [63:0] first, cnt, fin, need, off;
        int last, hit;
        r = '0;
        r.status = ST_OK;
        first = 64'(x.first_index);
        cnt = 64'(x.sample_count);
        fin = first + cnt;
        last = runs_used - 1;
        case (x.mode)
            MODE_OPEN: begin
                if (cap_open) r.status = ST_ALREADY;
                else if (!(reg_stride inside {3'd1, 3'd2, 3'd4})) r.status = ST_STRIDE;
                else if (reg_chan == 0 || reg_chan > MAX_CHANNELS) r.status = ST_CHANNELS;
                else if (reg_rate == 0) r.status = ST_RATE_ZERO;
                else if ($countones(reg_mask) != reg_chan) r.status = ST_MASK;
                else begin
                    geo_stride = 64'(reg_stride);
                    geo_chan = 64'(reg_chan);
                    geo_rate = 64'(reg_rate);
                    runs_used = 0;
                    {ext_lo, ext_hi, store_sz} = '0;
                    {n_blk, n_rej, n_smp, n_byt, n_dur, n_hole, n_miss} = '0;
                    cap_open = 1'b1;
                end
            end
            MODE_APPEND: begin
                if (!cap_open) r.status = ST_NOT_OPEN;
                else begin
                    if (!x.header_ok) r.status = ST_HEADER;
                    else if (x.block_stride != geo_stride || x.block_channels != geo_chan
                             || x.block_rate != geo_rate) r.status = ST_GEOMETRY;
                    else if (64'(x.payload_len) != cnt * geo_stride) r.status = ST_LENGTH;
                    else if (fin > M48) r.status = ST_LENGTH;
                    else if (runs_used > 0 && first < run_stop[last]) r.status = ST_OVERLAP;
                    else if (runs_used >= RUNS && first > run_stop[last])
                        r.status = ST_TABLE_FULL;
                    if (r.status != ST_OK) n_rej = sat(n_rej, 64'd1, M32);
                    else begin
                        if (runs_used == 0) begin
                            run_first[0] = first;
                            run_stop[0] = fin;
                            run_base[0] = store_sz;
                            runs_used = 1;
                        end else if (first > run_stop[last]) begin
                            r.hole_recorded = 1'b1;
                            r.hole_size = 48'(first - run_stop[last]);
                            n_hole = sat(n_hole, 64'd1, M32);
                            n_miss = sat(n_miss, first - run_stop[last], M48);
                            run_first[runs_used] = first;
                            run_stop[runs_used] = fin;
                            run_base[runs_used] = store_sz;
                            runs_used++;
                        end else run_stop[last] = fin;
                        store_sz = sat(store_sz, 64'(x.payload_len), M40);
                        if (ext_lo == 0 && ext_hi == 0) ext_lo = first;
                        ext_hi = fin;
                        n_blk = sat(n_blk, 64'd1, M32);
                        n_smp = sat(n_smp, cnt, M48);
                        n_byt = sat(n_byt, 64'(x.payload_len), M40);
                    end
                end
            end
            MODE_READ: begin
                if (runs_used == 0) r.status = ST_NO_DATA;
                else if (cnt != 0) begin
                    need = cnt * geo_stride;
                    if (64'(x.buffer_bytes) < need) r.status = ST_BUF_SMALL;
                    else begin
                        hit = -1;
                        for (int i = 0; i < runs_used; i++)
                            if (hit < 0 && first >= run_first[i] && fin <= run_stop[i]) hit = i;
                        if (hit < 0)
                            r.status = (first >= ext_lo && fin <= ext_hi) ? ST_SPANS_HOLE
                                                                          : ST_OUTSIDE;
                        else begin
                            off = run_base[hit] + (first - run_first[hit]) * geo_stride;
                            if (off + need > store_sz) r.status = ST_CORRUPT;
                            else begin
                                r.byte_offset = 40'(off);
                                r.samples_read = 32'(cnt);
                            end
                        end
                    end
                end
            end
            MODE_FLUSH: begin
                if (!cap_open) r.status = ST_NOT_OPEN;
                else n_dur = n_byt;
            end
            MODE_CLOSE: begin
                if (cap_open) begin
                    n_dur = n_byt;
                    cap_open = 1'b0;
                end
            end
            default: ;
        endcase
        r.blocks_written = 32'(n_blk);
        r.blocks_rejected = 32'(n_rej);
        r.samples_written = 48'(n_smp);
        r.bytes_written = 40'(n_byt);
        r.bytes_durable = 40'(n_dur);
        r.holes_recorded = 32'(n_hole);
        r.missing_total = 48'(n_miss);
        return r;
    endfunction

    function automatic void field_chk(input string nm, input logic [63:0] e,
                                      input logic [63:0] a);
        if (e !== a) begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, nm, e, a);
            fails++;
        end
    endfunction

    // input side: takes items from pending_items, predicts at acceptance
    always @(posedge i_clk) begin
        t_crt_in nxt;
        bit v;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            v = i_in_valid;
            nxt = i_in_data;
            if (i_in_valid && o_in_ready) begin
                expected_results.insert(expected_results.size(), index_step(i_in_data));
                v = 1'b0;
            end
            if (!v) begin
                if (gap_in > 0 && !quiet) gap_in--;
                else if (!quiet && $urandom_range(0, 7) == 0) gap_in = $urandom_range(0, 17);
                else if (pending_items.size() > 0) begin
                    nxt = pending_items.pop_front();
                    v = 1'b1;
                end
            end
            i_in_valid <= v;
            i_in_data <= nxt;
        end
    end

    // result side: compares each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_crt_out e;
        bit r;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result: expected none actual %0h", $time,
                             o_out_data);
                    fails++;
                end else begin
                    e = expected_results.pop_front();
                    field_chk("status", 64'(e.status), 64'(o_out_data.status));
                    field_chk("byte_offset", 64'(e.byte_offset),
                              64'(o_out_data.byte_offset));
                    field_chk("samples_read", 64'(e.samples_read),
                              64'(o_out_data.samples_read));
                    field_chk("hole_recorded", 64'(e.hole_recorded),
                              64'(o_out_data.hole_recorded));
                    field_chk("hole_size", 64'(e.hole_size), 64'(o_out_data.hole_size));
                    field_chk("blocks_written", 64'(e.blocks_written),
                              64'(o_out_data.blocks_written));
                    field_chk("blocks_rejected", 64'(e.blocks_rejected),
                              64'(o_out_data.blocks_rejected));
                    field_chk("samples_written", 64'(e.samples_written),
                              64'(o_out_data.samples_written));
                    field_chk("bytes_written", 64'(e.bytes_written),
                              64'(o_out_data.bytes_written));
                    field_chk("bytes_durable", 64'(e.bytes_durable),
                              64'(o_out_data.bytes_durable));
                    field_chk("holes_recorded", 64'(e.holes_recorded),
                              64'(o_out_data.holes_recorded));
                    field_chk("missing_total", 64'(e.missing_total),
                              64'(o_out_data.missing_total));
                end
            end
            if (gap_out > 0 && !quiet) begin
                gap_out--;
                r = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                gap_out = $urandom_range(0, 17);
                r = 1'b0;
            end else r = 1'b1;
            i_out_ready <= r;
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_STRIDE:   reg_stride = val[2:0];
            REG_CHANNELS: reg_chan = val[5:0];
            REG_RATE:     reg_rate = val;
            default:      reg_mask = val;
        endcase
    endtask

    // upper bits are junk on purpose; the block keeps only the field width
    task automatic set_geometry(input logic [2:0] s, input logic [5:0] c,
                                input logic [31:0] rt, input logic [31:0] m);
        apb_write(REG_STRIDE, 32'({$urandom, s}));
        apb_write(REG_CHANNELS, 32'({$urandom, c}));
        apb_write(REG_RATE, rt);
        apb_write(REG_MASK, m);
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || expected_results.size() != 0 || i_in_valid)
            @(negedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic logic [31:0] mask_of(input int n);
        logic [31:0] m;
        m = '0;
        while ($countones(m) < n) m[$urandom_range(0, 31)] = 1'b1;
        return m;
    endfunction

    function automatic t_crt_in noise();
        t_crt_in x;
        logic [223:0] w;
        w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        x = w[$bits(t_crt_in)-1:0];
        return x;
    endfunction

    function automatic t_crt_in op(input logic [2:0] m);
        t_crt_in x;
        x = noise();
        x.mode = m;
        return x;
    endfunction

    function automatic t_crt_in block(input logic [63:0] first, input logic [63:0] cnt);
        t_crt_in x;
        x = op(MODE_APPEND);
        x.first_index = 48'(first);
        x.sample_count = 32'(cnt);
        x.header_ok = 1'b1;
        x.block_stride = reg_stride;
        x.block_channels = reg_chan;
        x.block_rate = reg_rate;
        x.payload_len = 34'(cnt * reg_stride);
        return x;
    endfunction

    function automatic t_crt_in fetch(input logic [63:0] first, input logic [63:0] cnt,
                                      input logic [63:0] room);
        t_crt_in x;
        x = op(MODE_READ);
        x.first_index = 48'(first);
        x.sample_count = 32'(cnt);
        x.buffer_bytes = 34'(room);
        return x;
    endfunction

    task automatic push_read(input logic big);
        logic [63:0] f, c, room;
        f = (cur > span_lo) ? span_lo + ({$urandom, $urandom} % (cur - span_lo + 4))
                            : {$urandom, $urandom};
        c = big ? {32'd0, $urandom} : 64'($urandom_range(0, 64));
        room = c * reg_stride + $urandom_range(0, 7);
        if ($urandom_range(0, 9) == 0) room = {$urandom, $urandom} & 64'h3_FFFF_FFFF;
        if ($urandom_range(0, 19) == 0) f = {$urandom, $urandom};
        enqueue(fetch(f, c, room));
    endtask

    // one capture: close, open, then a mix weighted toward well-formed appends
    task automatic capture_phase(input int n, input int hole_pct, input logic big);
        t_crt_in x;
        logic [63:0] f, c;
        int k, r;
        cur = ($urandom_range(0, 3) == 0) ? ({$urandom, $urandom} & M48) >> $urandom_range(0, 40)
                                          : $urandom_range(0, 1000);
        span_lo = cur;
        enqueue(op(MODE_CLOSE));
        enqueue(op(MODE_OPEN));
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                c = big ? 64'hFFFF_FFFF - $urandom_range(0, 3)
                        : ($urandom_range(0, 15) == 0 ? {32'd0, $urandom}
                                                      : $urandom_range(0, 40));
                k = $urandom_range(0, 99);
                f = cur;
                if (k < hole_pct)
                    f = cur + (($urandom_range(0, 15) == 0) ? {24'd0, $urandom, 8'd0}
                                                            : $urandom_range(1, 500));
                else if (k < hole_pct + 5 && cur > span_lo)
                    f = cur - $urandom_range(1, 20);
                if ($urandom_range(0, 99) == 0) f = M48 - $urandom_range(0, 5);
                enqueue(block(f, c));
                if (f >= cur && f + c <= M48) cur = f + c;
            end else if (r < 80) begin
                push_read(big);
            end else if (r < 88) begin
                x = block(cur, $urandom_range(1, 30));
                case ($urandom_range(0, 4))
                    0: x.header_ok = 1'b0;
                    1: x.block_stride ^= 3'($urandom_range(1, 7));
                    2: x.block_channels ^= 6'($urandom_range(1, 63));
                    3: x.block_rate ^= $urandom_range(1, 32'hFFFF);
                    default: x.payload_len += 34'($urandom_range(1, 3));
                endcase
                enqueue(x);
            end else if (r < 95) begin
                enqueue(noise());
            end else if (r < 98) begin
                enqueue(op(MODE_FLUSH));
            end else begin
                enqueue(op(MODE_CLOSE));
                enqueue(op(MODE_OPEN));
            end
        end
        drain();
    endtask

    task automatic open_attempt(input logic [2:0] s, input logic [5:0] c,
                                input logic [31:0] rt, input logic [31:0] m);
        set_geometry(s, c, rt, m);
        enqueue(op(MODE_OPEN));
        drain();
    endtask

    initial begin
        int nch;
        t_crt_in d;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: reset geometry (stride 1, one channel)
        enqueue(fetch(0, 4, 100));          // no data yet
        enqueue(block(0, 4));               // not open
        enqueue(op(MODE_FLUSH));            // not open
        enqueue(op(MODE_CLOSE));            // close while closed
        enqueue(op(3'd5));
        enqueue(op(MODE_OPEN));
        enqueue(op(MODE_OPEN));             // already open
        enqueue(block(0, 10));
        enqueue(block(10, 5));              // extends run
        enqueue(block(12, 3));              // overlap
        enqueue(block(20, 5));              // hole of 5
        d = block(25, 2);
        d.header_ok = 1'b0;
        enqueue(d);
        d = block(25, 2);
        d.block_rate ^= 32'd1;
        enqueue(d);
        d = block(25, 2);
        d.payload_len = 34'd3;
        enqueue(d);
        enqueue(block(M48 - 5, 10));        // index overflow
        enqueue(block(25, 0));              // empty block
        enqueue(fetch(2, 4, 4));            // hit
        enqueue(fetch(2, 0, 0));            // zero length
        enqueue(fetch(2, 4, 1));            // buffer small
        enqueue(fetch(12, 10, 64));         // spans hole
        enqueue(fetch(30, 2, 64));          // outside
        enqueue(op(MODE_FLUSH));
        enqueue(op(MODE_CLOSE));
        enqueue(fetch(21, 3, 8));           // read while closed
        enqueue(op(3'd7));
        drain();

        open_attempt(3'd3, 6'd1, 32'd1, 32'd1);
        open_attempt(3'd0, 6'd1, 32'd1, 32'd1);
        open_attempt(3'd7, 6'd1, 32'd1, 32'd1);
        open_attempt(3'd4, 6'd0, 32'd1, 32'd0);
        open_attempt(3'd4, 6'd33, 32'd1, 32'hFFFF_FFFF);
        open_attempt(3'd4, 6'd63, 32'd1, 32'hFFFF_FFFF);
        open_attempt(3'd2, 6'd32, 32'd0, 32'hFFFF_FFFF);
        open_attempt(3'd2, 6'd3, 32'hFFFF_FFFF, 32'h0000_0003);

        // extremes of geometry
        set_geometry(3'd1, 6'd1, 32'd1, 32'h8000_0000);
        capture_phase(200, 25, 1'b0);
        set_geometry(3'd4, 6'd32, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        capture_phase(200, 25, 1'b0);

        // fill the run table past its size
        set_geometry(3'd2, 6'd5, 32'd48000, mask_of(5));
        capture_phase(140, 95, 1'b0);

        // huge blocks to saturate the byte counters
        set_geometry(3'd4, 6'd32, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        capture_phase(150, 0, 1'b1);

        for (int p = 0; p < 4; p++) begin
            nch = $urandom_range(1, 32);
            set_geometry(3'd1 << $urandom_range(0, 2), 6'(nch), $urandom | 32'd1,
                         mask_of(nch));
            if (p == 3) quiet = 1'b1;
            capture_phase(230, 20, 1'b0);
        end

        drain();
        if (fails == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    initial begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
